>>> design/sipf_pkg.sv
// Shared constants, types and microcode program of the servo instruction packet framer.
package sipf_pkg;

  localparam int JOINTS = 2;
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam logic [1:0] KIND_WRITE      = 2'd0;
  localparam logic [1:0] KIND_SYNC_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ       = 2'd2;
  localparam logic [1:0] KIND_SYNC_READ  = 2'd3;

  localparam logic [2:0] CFG_WRITE_OP      = 3'd0;
  localparam logic [2:0] CFG_SYNC_WRITE_OP = 3'd1;
  localparam logic [2:0] CFG_READ_OP       = 3'd2;
  localparam logic [2:0] CFG_SYNC_READ_OP  = 3'd3;
  localparam logic [2:0] CFG_BCAST_ID      = 3'd4;

  localparam logic [2:0]  MAX_SIZE      = 3'd4;
  localparam logic [15:0] CRC_POLY      = 16'h8005;
  localparam logic [7:0]  WRITE_LEN_ADD = 8'd5;
  localparam logic [7:0]  SYNC_LEN_ADD  = 8'd7;
  localparam logic [7:0]  READ_LEN      = 8'd7;
  localparam logic [7:0]  SYNC_READ_LEN = 8'(JOINTS + 7);

  typedef enum logic [3:0] {
    SRC_FF, SRC_FD, SRC_ZERO, SRC_PID, SRC_LEN_LO, SRC_OP, SRC_ADDR_LO,
    SRC_ADDR_HI, SRC_SIZE, SRC_VAL, SRC_JOINT, SRC_CRC_LO, SRC_CRC_HI
  } src_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_ADDR, BR_KIND, BR_WVAL, BR_SJOINT, BR_SVAL, BR_RJOINT, BR_END
  } br_t;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] S_HDR0    = 5'd0;
  localparam logic [PC_W-1:0] S_HDR1    = 5'd1;
  localparam logic [PC_W-1:0] S_HDR2    = 5'd2;
  localparam logic [PC_W-1:0] S_HDR3    = 5'd3;
  localparam logic [PC_W-1:0] S_PID     = 5'd4;
  localparam logic [PC_W-1:0] S_LEN_LO  = 5'd5;
  localparam logic [PC_W-1:0] S_LEN_HI  = 5'd6;
  localparam logic [PC_W-1:0] S_OP      = 5'd7;
  localparam logic [PC_W-1:0] S_ADDR_LO = 5'd8;
  localparam logic [PC_W-1:0] S_ADDR_HI = 5'd9;
  localparam logic [PC_W-1:0] S_WVAL    = 5'd10;
  localparam logic [PC_W-1:0] S_SIZE_LO = 5'd11;
  localparam logic [PC_W-1:0] S_SIZE_HI = 5'd12;
  localparam logic [PC_W-1:0] S_SJOINT  = 5'd13;
  localparam logic [PC_W-1:0] S_SVAL    = 5'd14;
  localparam logic [PC_W-1:0] S_RJOINT  = 5'd15;
  localparam logic [PC_W-1:0] S_CRC_LO  = 5'd16;
  localparam logic [PC_W-1:0] S_CRC_HI  = 5'd17;

  typedef struct packed {
    src_t            src;
    br_t             br;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  function automatic ucw_t sipf_ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{src: SRC_ZERO, br: BR_END, tgt: S_HDR0};
    case (pc)
      S_HDR0:    w = '{src: SRC_FF,      br: BR_NEXT,   tgt: S_HDR1};
      S_HDR1:    w = '{src: SRC_FF,      br: BR_NEXT,   tgt: S_HDR2};
      S_HDR2:    w = '{src: SRC_FD,      br: BR_NEXT,   tgt: S_HDR3};
      S_HDR3:    w = '{src: SRC_ZERO,    br: BR_NEXT,   tgt: S_PID};
      S_PID:     w = '{src: SRC_PID,     br: BR_NEXT,   tgt: S_LEN_LO};
      S_LEN_LO:  w = '{src: SRC_LEN_LO,  br: BR_NEXT,   tgt: S_LEN_HI};
      S_LEN_HI:  w = '{src: SRC_ZERO,    br: BR_NEXT,   tgt: S_OP};
      S_OP:      w = '{src: SRC_OP,      br: BR_NEXT,   tgt: S_ADDR_LO};
      S_ADDR_LO: w = '{src: SRC_ADDR_LO, br: BR_NEXT,   tgt: S_ADDR_HI};
      S_ADDR_HI: w = '{src: SRC_ADDR_HI, br: BR_ADDR,   tgt: S_CRC_LO};
      S_WVAL:    w = '{src: SRC_VAL,     br: BR_WVAL,   tgt: S_CRC_LO};
      S_SIZE_LO: w = '{src: SRC_SIZE,    br: BR_NEXT,   tgt: S_SIZE_HI};
      S_SIZE_HI: w = '{src: SRC_ZERO,    br: BR_KIND,   tgt: S_CRC_LO};
      S_SJOINT:  w = '{src: SRC_JOINT,   br: BR_SJOINT, tgt: S_CRC_LO};
      S_SVAL:    w = '{src: SRC_VAL,     br: BR_SVAL,   tgt: S_CRC_LO};
      S_RJOINT:  w = '{src: SRC_JOINT,   br: BR_RJOINT, tgt: S_CRC_LO};
      S_CRC_LO:  w = '{src: SRC_CRC_LO,  br: BR_NEXT,   tgt: S_CRC_HI};
      S_CRC_HI:  w = '{src: SRC_CRC_HI,  br: BR_END,    tgt: S_HDR0};
      default:   w = '{src: SRC_ZERO,    br: BR_END,    tgt: S_HDR0};
    endcase
    return w;
  endfunction

endpackage

>>> design/servo_instruction_packet_framer.sv
// Servo instruction packet framer top level: microcoded byte sequencer and output register.
// Each accepted request is sent as one instruction packet, one byte per item on the out
// channel, with out_last on the CRC high byte. Bytes per packet: write 12 + size, sync write
// 14 + JOINTS * (1 + size), read 14, sync read 14 + JOINTS (size clamped to 4). The microcode
// step counter issues one byte per cycle while out_ready holds; a new request is taken once
// the final byte has been loaded into the output register.
module servo_instruction_packet_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_servo_id,
  input  logic [15:0]        in_reg_address,
  input  logic [2:0]         in_data_size,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import sipf_pkg::*;

  logic [7:0] wr_op_r, swr_op_r, rd_op_r, srd_op_r, bcast_id_r;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [JW-1:0]   j_r, j_nxt;

  logic [1:0]  kind_r;
  logic [7:0]  id_r;
  logic [15:0] addr_r;
  logic [2:0]  size_r;
  logic [31:0] val_r;
  logic [7:0]  len_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic        acc, adv, idx_last, j_last, size_zero;
  logic [2:0]  size_c;
  logic [7:0]  len_c;
  logic [7:0]  byte_c;
  logic [15:0] crc;
  ucw_t        cw;

  assign in_ready = !busy_r;
  assign acc      = in_valid && in_ready;
  assign adv      = busy_r && (!out_valid_r || out_ready);
  assign cw       = sipf_ucode(pc_r);

  assign size_c = (in_data_size > MAX_SIZE) ? MAX_SIZE : in_data_size;

  // length never exceeds 8 bits for JOINTS up to 8
  always_comb begin
    case (in_kind)
      KIND_WRITE:      len_c = 8'({5'd0, size_c}) + WRITE_LEN_ADD;
      KIND_SYNC_WRITE: len_c = 8'((8'({5'd0, size_c}) + 8'd1) * 8'(JOINTS)) + SYNC_LEN_ADD;
      KIND_READ:       len_c = READ_LEN;
      default:         len_c = SYNC_READ_LEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_op_r    <= 8'd3;
      swr_op_r   <= 8'd131;
      rd_op_r    <= 8'd2;
      srd_op_r   <= 8'd130;
      bcast_id_r <= 8'd254;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRITE_OP:      wr_op_r    <= cfg_data;
        CFG_SYNC_WRITE_OP: swr_op_r   <= cfg_data;
        CFG_READ_OP:       rd_op_r    <= cfg_data;
        CFG_SYNC_READ_OP:  srd_op_r   <= cfg_data;
        CFG_BCAST_ID:      bcast_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind_r <= in_kind;
      id_r   <= in_servo_id;
      addr_r <= in_reg_address;
      size_r <= size_c;
      val_r  <= in_write_value;
      len_r  <= len_c;
    end
  end

  sipf_crc u_crc (
    .clk  (clk),
    .clr  (acc),
    .en   (adv && (cw.src != SRC_CRC_LO) && (cw.src != SRC_CRC_HI)),
    .data (byte_c),
    .crc  (crc)
  );

  always_comb begin
    case (cw.src)
      SRC_FF:      byte_c = 8'hFF;
      SRC_FD:      byte_c = 8'hFD;
      SRC_ZERO:    byte_c = 8'h00;
      SRC_PID:     byte_c = (kind_r inside {KIND_SYNC_WRITE, KIND_SYNC_READ})
                            ? bcast_id_r : id_r;
      SRC_LEN_LO:  byte_c = len_r;
      SRC_OP: begin
        case (kind_r)
          KIND_WRITE:      byte_c = wr_op_r;
          KIND_SYNC_WRITE: byte_c = swr_op_r;
          KIND_READ:       byte_c = rd_op_r;
          default:         byte_c = srd_op_r;
        endcase
      end
      SRC_ADDR_LO: byte_c = addr_r[7:0];
      SRC_ADDR_HI: byte_c = addr_r[15:8];
      SRC_SIZE:    byte_c = {5'd0, size_r};
      SRC_VAL:     byte_c = val_r[idx_r*8 +: 8];
      SRC_JOINT:   byte_c = 8'(j_r);
      SRC_CRC_LO:  byte_c = crc[7:0];
      SRC_CRC_HI:  byte_c = crc[15:8];
      default:     byte_c = 8'h00;
    endcase
  end

  assign idx_last  = ({1'b0, idx_r} + 3'd1) >= size_r;
  assign j_last    = j_r == JW'(JOINTS - 1);
  assign size_zero = size_r == 3'd0;

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (acc) begin
      busy_nxt = 1'b1;
      pc_nxt   = S_HDR0;
      idx_nxt  = '0;
      j_nxt    = '0;
    end else if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_c;
      out_last_nxt  = cw.br == BR_END;
      case (cw.br)
        BR_NEXT: pc_nxt = cw.tgt;
        BR_ADDR: begin
          if (kind_r == KIND_WRITE) begin
            pc_nxt = size_zero ? cw.tgt : S_WVAL;
          end else begin
            pc_nxt = S_SIZE_LO;
          end
        end
        BR_KIND: begin
          if (kind_r == KIND_SYNC_WRITE) begin
            pc_nxt = S_SJOINT;
          end else if (kind_r == KIND_SYNC_READ) begin
            pc_nxt = S_RJOINT;
          end else begin
            pc_nxt = cw.tgt;
          end
        end
        BR_WVAL: begin
          if (idx_last) begin
            idx_nxt = '0;
            pc_nxt  = cw.tgt;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        BR_SJOINT: begin
          if (!size_zero) begin
            pc_nxt = S_SVAL;
          end else if (j_last) begin
            pc_nxt = cw.tgt;
          end else begin
            j_nxt = j_r + JW'(1);
          end
        end
        BR_SVAL: begin
          if (!idx_last) begin
            idx_nxt = idx_r + 2'd1;
          end else begin
            idx_nxt = '0;
            if (j_last) begin
              pc_nxt = cw.tgt;
            end else begin
              j_nxt  = j_r + JW'(1);
              pc_nxt = S_SJOINT;
            end
          end
        end
        BR_RJOINT: begin
          if (j_last) begin
            pc_nxt = cw.tgt;
          end else begin
            j_nxt = j_r + JW'(1);
          end
        end
        BR_END: begin
          busy_nxt = 1'b0;
          pc_nxt   = cw.tgt;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= S_HDR0;
      idx_r       <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;

endmodule

>>> design/sipf_crc.sv
// CRC-16 (poly 0x8005, init 0, MSB first) accumulator, one byte per cycle while en is high.
module sipf_crc (
  input  logic        clk,
  input  logic        clr,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [15:0] crc
);
  import sipf_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc_nxt[15]) begin
        crc_nxt = {crc_nxt[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc_nxt = {crc_nxt[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      crc_r <= '0;
    end else if (en) begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule
